// ----- design/dnm_pkg.sv -----
`default_nettype none
package dnm_pkg;

   localparam int MAX_PATTERN   = 32;
   localparam int POSITION_BITS = 32;

   // Pattern registers hold at most 32 masks.
   localparam int PAT_CAP    = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
   localparam int WIN_DEPTH  = PAT_CAP;
   localparam int LEN_BITS   = $clog2(PAT_CAP + 1);
   localparam int IDX_BITS   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int OUT_BITS   = 32;
   localparam int EXT_BITS   = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;
   localparam int CODE_BITS  = 4;
   localparam int PAT_BITS   = 128;

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_LEN_BITS   = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_OFFSET   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_BITS  = 1;
   localparam int Q_CNT_BITS  = 2;

   // Classified symbol: window compare done, offset check still pending.
   typedef struct packed {
      logic                hit;
      logic [OUT_BITS-1:0] start;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- design/dnm_ifs.sv -----
`default_nettype none
interface dnm_req_if;
   logic                          valid;
   logic                          ready;
   logic [dnm_pkg::CODE_BITS-1:0] text_code;
   logic                          new_sequence;

   modport source (output valid, output text_code, output new_sequence, input ready);
   modport sink   (input valid, input text_code, input new_sequence, output ready);
endinterface

interface dnm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         match;
   logic [dnm_pkg::OUT_BITS-1:0] match_start;

   modport source (output valid, output match, output match_start, input ready);
   modport sink   (input valid, input match, input match_start, output ready);
endinterface
`default_nettype wire

// ----- design/dnm_front.sv -----
`default_nettype none
module dnm_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [dnm_pkg::CODE_BITS-1:0]  text_code,
   input  wire logic                           new_sequence,
   input  wire logic [dnm_pkg::PAT_BITS-1:0]   pattern,
   input  wire logic [dnm_pkg::LEN_BITS-1:0]   length,
   output dnm_pkg::entry_type                  entry
);
   import dnm_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [EXT_BITS-1:0]      OUT_MAX = EXT_BITS'({OUT_BITS{1'b1}});

   logic [WIN_DEPTH-1:0][CODE_BITS-1:0] window_ff, window_in;
   logic [POSITION_BITS-1:0]            seen_ff, seen_in;
   logic [POSITION_BITS-1:0]            prior, start;
   logic [POSITION_BITS-1:0]            len_ext;
   logic [EXT_BITS-1:0]                 start_ext;
   logic [WIN_DEPTH-1:0]                hit_vec;
   logic                                saturated, enough;
   logic [LEN_BITS-1:0]                 diff;
   logic [IDX_BITS-1:0]                 idx;
   logic [CODE_BITS-1:0]                sym, pmask;

   // newest symbol at place 0
   always_comb begin
      window_in[0] = text_code;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   always_comb begin
      len_ext   = POSITION_BITS'(length);
      prior     = new_sequence ? '0 : seen_ff;
      saturated = (prior == POS_MAX);
      seen_in   = saturated ? POS_MAX : prior + POSITION_BITS'(1);
      enough    = (seen_in >= len_ext);
      if (saturated) begin
         start = POS_MAX;
      end else if (enough) begin
         start = seen_in - len_ext;
      end else begin
         start = '0;
      end
      start_ext = EXT_BITS'(start);
   end

   // pattern mask j against the symbol j places after the window start
   always_comb begin
      for (int j = 0; j < WIN_DEPTH; j++) begin
         diff  = length - LEN_BITS'(1) - LEN_BITS'(j);
         idx   = IDX_BITS'(diff);
         sym   = window_in[idx];
         pmask = pattern[CODE_BITS*j +: CODE_BITS];
         if (LEN_BITS'(j) < length) begin
            hit_vec[j] = ((sym & pmask) == sym);
         end else begin
            hit_vec[j] = 1'b1;
         end
      end
   end

   always_comb begin
      entry.hit   = enough && (&hit_vec);
      entry.start = (start_ext > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : start_ext[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/dnm_queue.sv -----
`default_nettype none
module dnm_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  dnm_pkg::entry_type          push_entry,
   input  wire logic                   pop,
   output dnm_pkg::entry_type          head,
   output dnm_pkg::queue_status_type   status
);
   import dnm_pkg::*;

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [Q_PTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [Q_PTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   always_comb begin
      do_push = push && (count_ff != Q_CNT_BITS'(QUEUE_DEPTH));
      do_pop  = pop && (count_ff != '0);
      wptr_in = do_push ? wptr_ff + Q_PTR_BITS'(1) : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + Q_PTR_BITS'(1) : rptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + Q_CNT_BITS'(1);
         2'b01:   count_in = count_ff - Q_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
      head         = slots_ff[rptr_ff];
      status.valid = (count_ff != '0);
      status.full  = (count_ff == Q_CNT_BITS'(QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/dnm_back.sv -----
`default_nettype none
module dnm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  dnm_pkg::entry_type                 head,
   input  wire logic                          head_valid,
   output logic                               pop,
   input  wire logic [dnm_pkg::OUT_BITS-1:0]  start_offset,
   dnm_rsp_if.source                          rsp_chan
);
   import dnm_pkg::*;

   logic                valid_ff, valid_in;
   logic                match_ff, match_in;
   logic [OUT_BITS-1:0] start_ff, start_in;

   always_comb begin
      pop      = head_valid && (!valid_ff || rsp_chan.ready);
      match_in = head.hit && (head.start >= start_offset);
      start_in = match_in ? head.start : '0;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         match_ff <= match_in;
         start_ff <= start_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.match       = match_ff;
   assign rsp_chan.match_start = start_ff;

endmodule
`default_nettype wire

// ----- design/degenerate_nucleotide_matcher_core.sv -----
`default_nettype none
// IUPAC degenerate pattern matcher. Takes one 4-bit nucleotide mask per req
// transaction (A=1, C=2, G=4, T=8, ORed codes for ambiguity) and returns exactly
// one rsp transaction per symbol: match is 1 when every symbol of the window
// ending here is a subset of the pattern mask at that place, and match_start is
// the sequence position where that window starts (0 when there is no match).
// new_sequence restarts positions; windows must lie wholly inside the current
// sequence and start at or after start_offset; positions saturate at all ones.
// Throughput is one symbol per clock: the front stage does the window compare
// combinationally, so req.ready only drops when the two-entry queue is full.
// An accepted symbol is registered into the queue, then moves into the output
// register that drives rsp. Write the CSRs only while idle.
module degenerate_nucleotide_matcher_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   dnm_req_if.sink                                  req_chan,
   dnm_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [dnm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dnm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import dnm_pkg::*;

   // CSR file
   logic [CSR_DATA_BITS-1:0] pat_low_ff;
   logic [CSR_DATA_BITS-1:0] pat_high_ff;
   logic [CSR_LEN_BITS-1:0]  pat_len_ff;
   logic [OUT_BITS-1:0]      offset_ff;

   logic [PAT_BITS-1:0]      pattern;
   logic [LEN_BITS-1:0]      eff_len;

   entry_type                front_entry, q_head;
   queue_status_type         q_status;
   logic                     req_acc, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= CSR_LEN_BITS'(1);
         offset_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata;
            CSR_PATTERN_LENGTH: pat_len_ff  <= csr_wdata[CSR_LEN_BITS-1:0];
            CSR_START_OFFSET:   offset_ff   <= csr_wdata[OUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // length 0 acts as 1, anything past the cap acts as the cap
   always_comb begin
      pattern = {pat_high_ff, pat_low_ff};
      if (pat_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (pat_len_ff > CSR_LEN_BITS'(PAT_CAP)) begin
         eff_len = LEN_BITS'(PAT_CAP);
      end else begin
         eff_len = LEN_BITS'(pat_len_ff);
      end
   end

   // front: window shift, position count, subset compare
   assign req_chan.ready = !q_status.full;
   assign req_acc        = req_chan.valid && req_chan.ready;

   dnm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_acc),
      .text_code    (req_chan.text_code),
      .new_sequence (req_chan.new_sequence),
      .pattern      (pattern),
      .length       (eff_len),
      .entry        (front_entry)
   );

   // decouples the front from rsp backpressure
   dnm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_acc),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (q_head),
      .status     (q_status)
   );

   // back: offset check and output register
   dnm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .head_valid   (q_status.valid),
      .pop          (pop),
      .start_offset (offset_ff),
      .rsp_chan     (rsp_chan)
   );

   // a miss always reports start 0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.match) |-> (rsp_chan.match_start == '0))
      else $error("miss with nonzero match_start");

   // a hit never starts before the offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.match) |-> (rsp_chan.match_start >= offset_ff))
      else $error("match starts before start_offset");

   // an accepted symbol is queued or already pending in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (q_status.valid || rsp_chan.valid))
      else $error("accepted transaction lost");

   // a full queue means the output register is occupied
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> rsp_chan.valid)
      else $error("queue full with empty output stage");

endmodule
`default_nettype wire

// ----- tb/degenerate_nucleotide_matcher_core_tb.sv -----
`timescale 1ns / 1ps
module degenerate_nucleotide_matcher_core_tb;
   import dnm_pkg::*;

   // Watchdog: cycles with no transaction on either channel before giving up.
   // Worst legit gap is an idle run at 76% on either channel plus the CSR writes.
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;      // leave margin
   localparam int BLOCK_ITEMS  = 100;
   localparam int BLOCKS       = 5;      // per idling phase
   localparam int REPORT_LIMIT = 10;
   localparam longint unsigned POS_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic {ROW_SYMBOL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic        match;
      logic [31:0] start;
   } match_result_type;

   // One row of the directed sequence: either a CSR write or a symbol.
   // typed rows carry a hand-derived result, the rest use the predictor.
   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] reg_idx;
      logic [CSR_DATA_BITS-1:0]  reg_val;
      logic [CODE_BITS-1:0]      code;
      logic                      fresh;
      logic                      typed;
      logic                      exp_match;
      logic [31:0]               exp_start;
   } probe_row_type;

   localparam int PROBE_ROWS = 26;

   probe_row_type probe_rows [PROBE_ROWS] = '{
      // reset pattern is all-zero masks, length 1: only symbol 0 fits
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h0, 1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h1, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'hF, 1'b1, 1'b1, 1'b0, 32'd0},
      // wildcard masks: everything fits
      '{ROW_WRITE, CSR_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'hF, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b1, 1'b1, 32'd1},
      // length 0 acts as length 1
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd0, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h2, 1'b1, 1'b1, 1'b1, 32'd0},
      // pattern "GT", length 2
      '{ROW_WRITE, CSR_PATTERN_LOW, 64'h84, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd2, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b1, 1'b1, 1'b0, 32'd0},  // short window
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b0, 1'b1, 1'b0, 32'd0},
      // old sequence's G must not pair with the new T
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b0, 1'b0, 32'd0},
      // windows starting before position 3 are suppressed
      '{ROW_WRITE, CSR_START_OFFSET, 64'd3, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b1, 1'b1, 32'd4},
      // maximum offset: these windows do not match
      '{ROW_WRITE, CSR_START_OFFSET, 64'hFFFF_FFFF, 4'h0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h4, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_SYMBOL, CSR_PATTERN_LOW, 64'd0, 4'h8, 1'b0, 1'b1, 1'b0, 32'd0}
   };

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   dnm_req_if req_bus ();
   dnm_rsp_if rsp_bus ();

   degenerate_nucleotide_matcher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the CSRs and of the matcher's sliding window.
   logic [63:0]          pat_lo;
   logic [63:0]          pat_hi;
   logic [5:0]           pat_len;
   logic [31:0]          min_start;
   logic [3:0]           recent [32];      // newest symbol at index 0
   longint unsigned      seq_pos;          // symbols seen in current sequence

   match_result_type pending_matches [$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [3:0] pattern_nibble(input int j);
      logic [127:0] pat;
      pat = {pat_hi, pat_lo};
      return pat[4*j +: 4];
   endfunction

   // Length 0 runs as 1, anything past 32 runs as 32.
   function automatic int active_length();
      int len;
      len = pat_len;
      if (len == 0) len = 1;
      if (len > 32) len = 32;
      return len;
   endfunction

   function automatic void store_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_PATTERN_LOW:    pat_lo    = val;
         CSR_PATTERN_HIGH:   pat_hi    = val;
         CSR_PATTERN_LENGTH: pat_len   = val[5:0];
         CSR_START_OFFSET:   min_start = val[31:0];
      endcase
   endfunction

   // Shift the symbol in, advance the position and judge the window ending here.
   function automatic match_result_type predict_match(input logic [3:0] code,
                                                      input logic fresh);
      int               len;
      longint unsigned  prior;
      longint unsigned  after;
      longint unsigned  start;
      logic             ok;
      logic [3:0]       sym;
      match_result_type res;
      len   = active_length();
      prior = fresh ? 0 : seq_pos;
      for (int i = 31; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = code;
      after   = (prior >= POS_MAX) ? POS_MAX : prior + 1;
      seq_pos = after;
      if (prior >= POS_MAX) start = POS_MAX;
      else start = (after >= len) ? after - len : 0;
      // window must lie wholly inside the current sequence
      ok = (after >= len);
      // oldest window symbol lines up with pattern mask 0
      for (int j = 0; j < len; j++) begin
         sym = recent[len-1-j];
         if ((sym & pattern_nibble(j)) != sym) ok = 1'b0;
      end
      if (start < min_start) ok = 1'b0;
      res.match = ok;
      res.start = ok ? start[31:0] : 32'd0;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", what);
   endtask

   // Present one symbol, hold it until the req transaction, then log the
   // expected result. Random idle cycles go ahead of the symbol.
   task automatic push_symbol(input logic [3:0] code, input logic fresh,
                              input logic typed, input logic exp_match,
                              input logic [31:0] exp_start);
      match_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.text_code    <= code;
      req_bus.new_sequence <= fresh;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_match(code, fresh);
      if (typed) pending_matches.push_back({exp_match, exp_start});
      else pending_matches.push_back(predicted);
   endtask

   // Stop sending and wait for every outstanding result.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      store_reg(idx, val);
      @(posedge clock);
   endtask

   // New random setting, then a stream that is mostly planted windows
   // (symbols drawn as subsets of the pattern masks) mixed with noise.
   task automatic run_block(input int items, input int forced_len);
      logic [127:0] pat;
      logic [5:0]   len_val;
      logic [31:0]  off_val;
      logic [63:0]  junk;
      logic [3:0]   code;
      logic         lead_fresh;
      int           sent;
      int           len;
      int           burst;
      settle();
      for (int k = 0; k < 32; k++)
         pat[4*k +: 4] = $urandom_range(1) ? 4'hF : 4'($urandom_range(15));
      case ($urandom_range(9))
         0:       len_val = 6'd0;
         1:       len_val = 6'd32;
         2:       len_val = 6'($urandom_range(63, 33));
         default: len_val = 6'($urandom_range(8, 1));
      endcase
      if (forced_len >= 0) len_val = 6'(forced_len);
      case ($urandom_range(5))
         2:       off_val = $urandom_range(30);
         3:       off_val = 32'hFFFF_FFFF;
         4:       off_val = $urandom();
         5:       off_val = $urandom_range(200);
         default: off_val = 32'd0;
      endcase
      // bits above the register width must be ignored
      junk = $urandom_range(1) ? {$urandom(), $urandom()} : 64'd0;
      write_reg(CSR_PATTERN_LOW, pat[63:0]);
      write_reg(CSR_PATTERN_HIGH, pat[127:64]);
      write_reg(CSR_PATTERN_LENGTH, {junk[63:6], len_val});
      write_reg(CSR_START_OFFSET, {junk[63:32], off_val});
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 60) begin
            len        = active_length();
            lead_fresh = ($urandom_range(3) == 0);
            for (int j = 0; j < len; j++) begin
               code = 4'($urandom_range(15)) & pattern_nibble(j);
               if ($urandom_range(19) == 0) code = 4'($urandom_range(15));  // broken window
               push_symbol(code, lead_fresh && (j == 0), 1'b0, 1'b0, 32'd0);
               sent++;
            end
         end else begin
            burst = $urandom_range(8, 1);
            for (int b = 0; b < burst; b++) begin
               push_symbol(4'($urandom_range(15)), $urandom_range(19) == 0,
                           1'b0, 1'b0, 32'd0);
               sent++;
            end
         end
      end
   endtask

   // Receiver: random backpressure on rsp.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result checker: each rsp transaction against the oldest expectation.
   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp: match=%0b start=%0d",
                                      rsp_bus.match, rsp_bus.match_start));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_bus.match !== want.match || rsp_bus.match_start !== want.start)
               report_mismatch($sformatf(
                  "rsp mismatch: expected match=%0b start=%0d, got match=%0b start=%0d",
                  want.match, want.start, rsp_bus.match, rsp_bus.match_start));
         end
      end
   end

   // Watchdog on transaction activity.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("degenerate_nucleotide_matcher_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.text_code    = '0;
      req_bus.new_sequence = 1'b0;
      send_idle_pct        = 0;
      recv_idle_pct        = 0;
      mismatch_count       = 0;
      pat_lo               = '0;
      pat_hi               = '0;
      pat_len              = 6'd1;
      min_start            = '0;
      seq_pos              = 0;
      for (int i = 0; i < 32; i++) recent[i] = 4'h0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass.
      for (int r = 0; r < PROBE_ROWS; r++) begin
         if (probe_rows[r].kind == ROW_WRITE) begin
            settle();
            write_reg(probe_rows[r].reg_idx, probe_rows[r].reg_val);
         end else begin
            push_symbol(probe_rows[r].code, probe_rows[r].fresh, probe_rows[r].typed,
                        probe_rows[r].exp_match, probe_rows[r].exp_start);
         end
      end

      // Random pass in three idling phases: sender-light/receiver-heavy,
      // swapped, then no idling. First block of each forces a length extreme.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 76 : 0;
         recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 15 : 0;
         for (int blk = 0; blk < BLOCKS; blk++)
            run_block(BLOCK_ITEMS, (blk != 0) ? -1 : (phase == 0) ? 32 : (phase == 1) ? 63 : 0);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("degenerate_nucleotide_matcher_core verification clean");
      else
         $display("degenerate_nucleotide_matcher_core verification failed");
      $finish;
   end

endmodule
